>>> hw/rtl/jitc_pkg.sv
// ----------------------------------------------------------------------------
// jitc_pkg: shared types and constants
// Item formats, action and register codes, sequencer states for the
// joint impedance torque controller.
// ----------------------------------------------------------------------------
package jitc_pkg;

  localparam int JOINT_COUNT = 7;
  localparam int JOINT_W     = 3;
  localparam int VALUE_W     = 32;
  localparam int GAIN_W      = 31;
  localparam int BLEND_W     = 17;
  localparam int CFG_IDX_W   = 2;

  // Velocity filter weights on a Q0.16 scale (0.99 and 0.01)
  localparam logic [16:0] W_NEW   = 17'd64881;
  localparam logic [16:0] W_OLD   = 17'd655;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_ELEMENT = 3'd1;
  localparam logic [2:0] ACT_SETUP   = 3'd2;
  localparam logic [2:0] ACT_GAINS   = 3'd3;
  localparam logic [2:0] ACT_START   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CORIOLIS_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_STEP_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BLEND      = 2'd2;

  localparam logic KIND_TORQUE  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [2:0]          action;
    logic [JOINT_W-1:0]  joint;
    logic signed [31:0]  position;
    logic signed [31:0]  velocity;
    logic signed [31:0]  coriolis;
    logic signed [31:0]  prior_torque;
    logic                last;
    logic signed [31:0]  lower_limit;
    logic signed [31:0]  upper_limit;
    logic [30:0]         speed_limit;
    logic [30:0]         stiffness;
    logic [30:0]         damping;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [JOINT_W-1:0]  joint_out;
    logic signed [31:0]  torque;
    logic                accepted;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8,
    S_WB, S_SWEEP, S_VERDICT
  } state_t;

endpackage

>>> hw/rtl/jitc_if.sv
// ----------------------------------------------------------------------------
// jitc channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface jitc_in_if;
  logic               valid;
  logic               ready;
  jitc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jitc_out_if;
  logic                valid;
  logic                ready;
  jitc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jitc_cfg_if;
  logic              valid;
  logic              ready;
  jitc_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/joint_impedance_torque_controller.sv
// ----------------------------------------------------------------------------
// joint_impedance_torque_controller
// Per-joint impedance torque law with torque step limit, gain blending and
// buffered command sets, on one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Tick: after dispatch, states T0 to T8 run the nine products through one
//   multiplier, then write-back S_WB waits for a free output register.
// Command element: dispatch only; a last element adds a target sweep over
//   all joints and a verdict state. Setup, gain targets, start: dispatch, no result.
// Reset (rst_n, synchronous, active low) clears targets, filters, gains,
//   counters and registers; limit and pending stores are not cleared.
// ----------------------------------------------------------------------------
module joint_impedance_torque_controller (
  input  logic       clk,
  input  logic       rst_n,
  jitc_in_if.sink    in_ch,
  jitc_out_if.source out_ch,
  jitc_cfg_if.sink   cfg_ch
);
  import jitc_pkg::*;

  // Q16.16 product magnitude rounded half away from zero, then saturated
  function automatic logic signed [31:0] sat_mul(input logic signed [67:0] p);
    logic [67:0] mag;
    logic [51:0] r;
    mag = p[67] ? (~p + 68'd1) : p;
    r   = 52'((mag + 68'd32768) >> 16);
    if (p[67]) begin
      if (r > 52'h80000000) return 32'sh80000000;
      return 32'(~r + 52'd1);
    end
    if (r > 52'h7FFFFFFF) return 32'sh7FFFFFFF;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x[33:31] != {3{x[33]}}) return x[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
    return x[31:0];
  endfunction

  // Configuration registers
  logic signed [31:0] coriolis_scale_r;
  logic [30:0]        torque_step_max_r;
  logic [16:0]        gain_blend_r;

  // Per-joint state
  logic signed [31:0] tp_r   [JOINT_COUNT];
  logic signed [31:0] tv_r   [JOINT_COUNT];
  logic signed [31:0] fv_r   [JOINT_COUNT];
  logic signed [31:0] prev_r [JOINT_COUNT];
  logic [GAIN_W-1:0]  snow_r [JOINT_COUNT];
  logic [GAIN_W-1:0]  dnow_r [JOINT_COUNT];
  logic [GAIN_W-1:0]  sgoal_r[JOINT_COUNT];
  logic [GAIN_W-1:0]  dgoal_r[JOINT_COUNT];
  // Written before use, no reset
  logic signed [31:0] floor_r[JOINT_COUNT];
  logic signed [31:0] ceil_r [JOINT_COUNT];
  logic [30:0]        vceil_r[JOINT_COUNT];
  logic signed [31:0] pp_r   [JOINT_COUNT];
  logic signed [31:0] pv_r   [JOINT_COUNT];

  logic [3:0] seen_r;
  logic       viol_r;

  // Sequencer and datapath registers
  state_t             state_r, state_nxt;
  in_item_t           item_r;
  logic signed [67:0] prod_r;
  logic signed [49:0] acc_r;
  logic signed [33:0] tau_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] fvn_r;
  logic signed [31:0] res_r;
  logic [GAIN_W-1:0]  sblend_r;
  logic               verdict_r;
  logic [JOINT_W-1:0] sweep_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [JOINT_W-1:0] jr;
  logic               joint_ok;
  logic [16:0]        g, g_inv;
  logic signed [33:0] mul_a, mul_b;
  logic signed [50:0] acc_sum;
  logic               out_free;
  logic               out_load;
  logic [3:0]         seen_inc;
  logic [32:0]        vel_mag;
  logic               elem_bad;
  logic signed [32:0] step_s;
  logic signed [32:0] diff_c;

  assign jr       = item_r.joint;
  assign joint_ok = (item_r.joint < JOINT_W'(JOINT_COUNT));
  assign g        = (gain_blend_r > ONE_Q16) ? ONE_Q16 : gain_blend_r;
  assign g_inv    = ONE_Q16 - g;
  assign acc_sum  = 51'(acc_r) + 51'(prod_r[49:0]) + 51'sd32768;
  assign out_free = !out_valid_r || out_ch.ready;
  // a new result enters the output register this cycle
  assign out_load = out_free && (state_r == S_WB || state_r == S_VERDICT);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Command element checks
  assign seen_inc = (seen_r < 4'd15) ? seen_r + 4'd1 : seen_r;
  assign vel_mag  = item_r.velocity[31] ? 33'(-34'(item_r.velocity))
                                        : 33'(item_r.velocity);
  assign elem_bad = !joint_ok ||
                    (item_r.position < floor_r[jr]) ||
                    (item_r.position > ceil_r[jr]) ||
                    (vel_mag > 33'(vceil_r[jr]));

  // Torque step clamp
  assign step_s = 33'(torque_step_max_r);
  always_comb begin
    diff_c = diff_r;
    if (diff_r > step_s) diff_c = step_s;
    if (diff_r < -step_s) diff_c = -step_s;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_T0: begin mul_a = 34'(W_OLD); mul_b = 34'(fv_r[jr]); end
      S_T1: begin mul_a = 34'(W_NEW); mul_b = 34'(item_r.velocity); end
      S_T2: begin mul_a = 34'(coriolis_scale_r); mul_b = 34'(item_r.coriolis); end
      S_T3: begin
        mul_a = 34'(snow_r[jr]);
        mul_b = 34'(tp_r[jr]) - 34'(item_r.position);
      end
      S_T4: begin
        mul_a = 34'(dnow_r[jr]);
        mul_b = 34'(tv_r[jr]) - 34'(fvn_r);
      end
      S_T5: begin mul_a = 34'(g);     mul_b = 34'(sgoal_r[jr]); end
      S_T6: begin mul_a = 34'(g_inv); mul_b = 34'(snow_r[jr]); end
      S_T7: begin mul_a = 34'(g);     mul_b = 34'(dgoal_r[jr]); end
      S_T8: begin mul_a = 34'(g_inv); mul_b = 34'(dnow_r[jr]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_ch.valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        if (item_r.action == ACT_ELEMENT) begin
          if (item_r.last) state_nxt = S_SWEEP;
        end else if (item_r.action == ACT_TICK && joint_ok) begin
          state_nxt = S_T0;
        end
      end
      S_T0: state_nxt = S_T1;
      S_T1: state_nxt = S_T2;
      S_T2: state_nxt = S_T3;
      S_T3: state_nxt = S_T4;
      S_T4: state_nxt = S_T5;
      S_T5: state_nxt = S_T6;
      S_T6: state_nxt = S_T7;
      S_T7: state_nxt = S_T8;
      S_T8: state_nxt = S_WB;
      S_WB:      if (out_free) state_nxt = S_IDLE;
      S_SWEEP:   if (sweep_r == JOINT_W'(JOINT_COUNT - 1)) state_nxt = S_VERDICT;
      S_VERDICT: if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coriolis_scale_r  <= 32'sd65536;
      torque_step_max_r <= 31'd65536;
      gain_blend_r      <= 17'd328;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        CFG_CORIOLIS_SCALE:  coriolis_scale_r  <= cfg_ch.data.value;
        CFG_TORQUE_STEP_MAX: torque_step_max_r <= cfg_ch.data.value[30:0];
        CFG_GAIN_BLEND:      gain_blend_r      <= cfg_ch.data.value[16:0];
        default: ;
      endcase
    end
  end

  // Stores without reset and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) item_r <= in_ch.data;
    if (state_r != S_WB) prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_DISPATCH: begin
        if (item_r.action == ACT_ELEMENT && joint_ok) begin
          pp_r[jr] <= item_r.position;
          pv_r[jr] <= item_r.velocity;
        end
        if (item_r.action == ACT_SETUP && joint_ok) begin
          floor_r[jr] <= item_r.lower_limit;
          ceil_r[jr]  <= item_r.upper_limit;
          vceil_r[jr] <= item_r.speed_limit;
        end
        verdict_r <= (seen_inc == 4'(JOINT_COUNT)) && !viol_r && !elem_bad;
        sweep_r   <= '0;
      end
      S_T1: acc_r <= prod_r[49:0];
      S_T2: fvn_r <= acc_sum[47:16];
      S_T3: tau_r <= 34'(sat_mul(prod_r));
      S_T4: tau_r <= tau_r + 34'(sat_mul(prod_r));
      S_T5: tau_r <= tau_r + 34'(sat_mul(prod_r));
      S_T6: begin
        acc_r  <= prod_r[49:0];
        diff_r <= 33'(sat32(tau_r)) - 33'(item_r.prior_torque);
      end
      S_T7: begin
        sblend_r <= acc_sum[46:16];
        res_r    <= sat32(34'(item_r.prior_torque) + 34'(diff_c));
      end
      S_T8: acc_r <= prod_r[49:0];
      S_SWEEP: sweep_r <= sweep_r + JOINT_W'(1);
      default: ;
    endcase
  end

  // Per-joint state with reset, element bookkeeping, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        tp_r[i] <= '0; tv_r[i] <= '0; fv_r[i] <= '0; prev_r[i] <= '0;
        snow_r[i] <= '0; dnow_r[i] <= '0; sgoal_r[i] <= '0; dgoal_r[i] <= '0;
      end
      seen_r      <= '0;
      viol_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_DISPATCH: begin
          if (item_r.action == ACT_ELEMENT) begin
            if (item_r.last) begin
              seen_r <= '0;
              viol_r <= 1'b0;
            end else begin
              seen_r <= seen_inc;
              viol_r <= viol_r | elem_bad;
            end
          end else if (joint_ok) begin
            if (item_r.action == ACT_SETUP) begin
              snow_r[jr]  <= item_r.stiffness;
              sgoal_r[jr] <= item_r.stiffness;
              dnow_r[jr]  <= item_r.damping;
              dgoal_r[jr] <= item_r.damping;
            end else if (item_r.action == ACT_GAINS) begin
              sgoal_r[jr] <= item_r.stiffness;
              dgoal_r[jr] <= item_r.damping;
            end else if (item_r.action == ACT_START) begin
              prev_r[jr] <= item_r.position;
              tp_r[jr]   <= item_r.position;
              fv_r[jr]   <= '0;
              tv_r[jr]   <= '0;
            end
          end
        end
        S_WB: if (out_free) begin
          fv_r[jr]   <= fvn_r;
          prev_r[jr] <= item_r.position;
          snow_r[jr] <= sblend_r;
          dnow_r[jr] <= acc_sum[46:16];
          out_valid_r <= 1'b1;
          out_data_r  <= '{kind: KIND_TORQUE, joint_out: jr, torque: res_r,
                           accepted: 1'b0};
        end
        S_SWEEP: begin
          tp_r[sweep_r] <= verdict_r ? pp_r[sweep_r] : prev_r[sweep_r];
          if (verdict_r) tv_r[sweep_r] <= pv_r[sweep_r];
        end
        S_VERDICT: if (out_free) begin
          out_valid_r <= 1'b1;
          out_data_r  <= '{kind: KIND_VERDICT, joint_out: '0, torque: '0,
                           accepted: verdict_r};
        end
        default: ;
      endcase
    end
  end

  // A result appears only from a write-back or verdict step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_WB || $past(state_r) == S_VERDICT))
    else $error("result raised outside write-back/verdict");

  // The tick sequence only runs for a joint in range
  a_tick_joint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T0) |-> joint_ok)
    else $error("tick sequence for joint out of range");

  // An input transfer always leads to dispatch
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_DISPATCH))
    else $error("input transfer not dispatched");

endmodule

>>> tb/jitc_tb_types.sv
// ----------------------------------------------------------------------------
// jitc_tb_types: torque law predictor and expected-result store
// Scoreboard class that mirrors the controller's per-joint state, predicts the
// result, if any, of every accepted input transfer and checks the results that follow.
// ----------------------------------------------------------------------------
package jitc_tb_types;
  import jitc_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  class torque_scoreboard;
    longint tgt_pos[JOINT_COUNT], tgt_vel[JOINT_COUNT], filt_vel[JOINT_COUNT];
    longint prev_pos[JOINT_COUNT];
    longint k_now[JOINT_COUNT], d_now[JOINT_COUNT];
    longint k_goal[JOINT_COUNT], d_goal[JOINT_COUNT];
    longint pos_lo[JOINT_COUNT], pos_hi[JOINT_COUNT], vel_hi[JOINT_COUNT];
    longint pend_pos[JOINT_COUNT], pend_vel[JOINT_COUNT];
    int     elem_count;
    bit     violated;
    longint cor_scale, step_max, blend_w;
    out_item_t expected_results[$];
    int     failures;

    function new();
      for (int i = 0; i < JOINT_COUNT; i++) begin
        tgt_pos[i] = 0; tgt_vel[i] = 0; filt_vel[i] = 0; prev_pos[i] = 0;
        k_now[i] = 0; d_now[i] = 0; k_goal[i] = 0; d_goal[i] = 0;
        pos_lo[i] = 0; pos_hi[i] = 0; vel_hi[i] = 0;
        pend_pos[i] = 0; pend_vel[i] = 0;
      end
      elem_count = 0; violated = 0;
      cor_scale = 65536; step_max = 65536; blend_w = 328;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_CORIOLIS_SCALE:  cor_scale = longint'(signed'(val));
        CFG_TORQUE_STEP_MAX: step_max = longint'(val[30:0]);
        CFG_GAIN_BLEND:      blend_w = longint'(val[16:0]);
        default: ;
      endcase
    endfunction

    // rounded magnitude product, saturated to 32 bits signed
    function longint qmul(longint a, longint b);
      bit neg;
      longint unsigned ma, mb, r;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r = (ma * mb + 32768) >> 16;
      if (neg) begin
        if (r > 64'd2147483648) r = 64'd2147483648;
        return -longint'(r);
      end
      if (r > 64'd2147483647) r = 64'd2147483647;
      return longint'(r);
    endfunction

    function longint clamp32(longint x);
      if (x > VMAX) return VMAX;
      if (x < VMIN) return VMIN;
      return x;
    endfunction

    function void note_input(in_item_t it);
      int j;
      bit ok, acc;
      longint pos, vel, mag, fv, tau, diff, g;
      out_item_t r;
      j = it.joint;
      ok = j < JOINT_COUNT;
      pos = longint'(it.position);
      vel = longint'(it.velocity);
      r = '0;
      case (it.action)
        ACT_ELEMENT: begin
          if (elem_count < 15) elem_count++;
          if (ok) begin
            mag = vel < 0 ? -vel : vel;
            pend_pos[j] = pos; pend_vel[j] = vel;
            if (pos < pos_lo[j] || pos > pos_hi[j] || mag > vel_hi[j]) violated = 1;
          end else violated = 1;
          if (it.last) begin
            acc = elem_count == JOINT_COUNT && !violated;
            for (int i = 0; i < JOINT_COUNT; i++) begin
              if (acc) begin
                tgt_pos[i] = pend_pos[i]; tgt_vel[i] = pend_vel[i];
              end else tgt_pos[i] = prev_pos[i];
            end
            elem_count = 0; violated = 0;
            r.kind = KIND_VERDICT; r.accepted = acc;
            expected_results.insert(expected_results.size(), r);
          end
        end
        ACT_TICK: if (ok) begin
          g = blend_w > 65536 ? 65536 : blend_w;
          // floor division keeps halves toward plus infinity
          fv = (655 * filt_vel[j] + 64881 * vel + 32768) >>> 16;
          filt_vel[j] = fv;
          tau = clamp32(qmul(cor_scale, longint'(it.coriolis))
                + qmul(k_now[j], tgt_pos[j] - pos) + qmul(d_now[j], tgt_vel[j] - fv));
          diff = tau - longint'(it.prior_torque);
          if (diff > step_max) diff = step_max;
          if (diff < -step_max) diff = -step_max;
          prev_pos[j] = pos;
          k_now[j] = (g * k_goal[j] + (65536 - g) * k_now[j] + 32768) >> 16;
          d_now[j] = (g * d_goal[j] + (65536 - g) * d_now[j] + 32768) >> 16;
          r.kind = KIND_TORQUE; r.joint_out = JOINT_W'(j);
          r.torque = 32'(clamp32(longint'(it.prior_torque) + diff));
          expected_results.insert(expected_results.size(), r);
        end
        ACT_SETUP: if (ok) begin
          pos_lo[j] = longint'(it.lower_limit); pos_hi[j] = longint'(it.upper_limit);
          vel_hi[j] = longint'(it.speed_limit);
          k_now[j] = longint'(it.stiffness); k_goal[j] = k_now[j];
          d_now[j] = longint'(it.damping); d_goal[j] = d_now[j];
        end
        ACT_GAINS: if (ok) begin
          k_goal[j] = longint'(it.stiffness); d_goal[j] = longint'(it.damping);
        end
        ACT_START: if (ok) begin
          prev_pos[j] = pos; tgt_pos[j] = pos; filt_vel[j] = 0; tgt_vel[j] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d torque=%0d", got.kind, got.torque);
        failures++;
        return;
      end
      e = expected_results.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind); failures++;
      end
      if (got.joint_out !== e.joint_out) begin
        $error("joint_out: expected %0d, got %0d", e.joint_out, got.joint_out);
        failures++;
      end
      if (got.torque !== e.torque) begin
        $error("torque: expected %0d, got %0d", e.torque, got.torque); failures++;
      end
      if (got.accepted !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, got.accepted);
        failures++;
      end
    endfunction
  endclass
endpackage

>>> tb/joint_impedance_torque_controller_tb.sv
// ----------------------------------------------------------------------------
// joint_impedance_torque_controller_tb: self-checking testbench
// Loads joint setups, runs directed and random ticks, gain updates, starts and
// command sets (well formed, short, long, out of limits) under random gaps and
// stalls on both channels, with register changes between phases. Every result
// is compared field by field against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module joint_impedance_torque_controller_tb;
  import jitc_pkg::*;
  import jitc_tb_types::*;

  localparam int STALL_LIMIT = 2000;   // cycles without any transfer
  localparam int DRAIN_CYCLES = 40;    // beyond the longest sweep plus verdict

  logic clk = 0;
  logic rst_n = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  jitc_in_if  in_ch();
  jitc_out_if out_ch();
  jitc_cfg_if cfg_ch();

  joint_impedance_torque_controller DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  torque_scoreboard sb = new();
  int   idle_cycles = 0;
  int   batch_len;       // random count of back-to-back transfers
  longint lim_lo[JOINT_COUNT], lim_hi[JOINT_COUNT], spd[JOINT_COUNT];

  initial begin
    in_ch.valid = 0; in_ch.data = '0;
    cfg_ch.valid = 0; cfg_ch.data = '0;
    out_ch.ready = 0;
  end

  // watchdog: any transfer clears the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: sample at rising edge, vary ready at falling edge
  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

  initial begin : result_ready
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      // stretches of full-rate draining between random stalls
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // valid stays up after a transfer until the next item or drain decides;
  // the block is never ready at the falling edge that follows a transfer
  task automatic send_item(in_item_t it);
    int gap;
    gap = (batch_len > 0) ? 0 : $urandom_range(0, 16);
    if (batch_len > 0) batch_len--;
    else if ($urandom_range(0, 7) == 0) batch_len = $urandom_range(4, 20);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.data <= '{index: idx, value: val};
    cfg_ch.valid <= 1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_register(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 0;
    @(negedge clk);
  endtask

  // wait for all expected results, then let trailing work finish
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rnd_gain();
    case ($urandom_range(0, 4))
      0: return 31'h7fffffff;
      1: return '0;
      2: return 31'($urandom_range(0, 1 << 22));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic setup_joint(int j, bit wide);
    in_item_t it;
    it = '0;
    it.action = ACT_SETUP; it.joint = JOINT_W'(j);
    if (wide) begin
      it.lower_limit = 32'h80000000; it.upper_limit = 32'h7fffffff;
      it.speed_limit = 31'h7fffffff;
    end else begin
      it.lower_limit = -32'sd1 * 32'($urandom_range(0, 1 << 24));
      it.upper_limit = 32'($urandom_range(0, 1 << 24));
      it.speed_limit = 31'($urandom_range(0, 1 << 22));
    end
    it.stiffness = rnd_gain(); it.damping = rnd_gain();
    it.position = rnd32(); it.velocity = rnd32();
    it.coriolis = rnd32(); it.prior_torque = rnd32(); it.last = 1'($urandom);
    lim_lo[j] = longint'(it.lower_limit); lim_hi[j] = longint'(it.upper_limit);
    spd[j] = longint'(it.speed_limit);
    send_item(it);
  endtask

  function automatic in_item_t random_noise();
    in_item_t it;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic send_tick(int j);
    in_item_t it;
    it = random_noise();
    it.action = ACT_TICK; it.joint = JOINT_W'(j);
    it.position = rnd32(); it.velocity = rnd32();
    it.coriolis = rnd32(); it.prior_torque = rnd32();
    send_item(it);
  endtask

  // command set; elements inside limits unless broken is set
  task automatic send_set(int count, bit broken, bit bad_joint);
    in_item_t it;
    longint p, v;
    int bad_at;
    bad_at = $urandom_range(0, count - 1);
    for (int k = 0; k < count; k++) begin
      it = random_noise();
      it.action = ACT_ELEMENT;
      it.joint = JOINT_W'(k % JOINT_COUNT);
      p = lim_lo[it.joint] + longint'($urandom_range(0, 1000)) *
          ((lim_hi[it.joint] - lim_lo[it.joint]) / 1000);
      v = longint'($urandom_range(0, 1000)) * (spd[it.joint] / 1000);
      if ($urandom_range(0, 1)) v = -v;
      if (broken && k == bad_at) begin
        if ($urandom_range(0, 1)) p = lim_hi[it.joint] + 1;
        else v = spd[it.joint] + 1;
      end
      if (bad_joint && k == bad_at) it.joint = JOINT_W'(7);
      it.position = 32'(p); it.velocity = 32'(v);
      it.last = (k == count - 1);
      send_item(it);
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    int n, sel;
    batch_len = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // -------- directed part --------
    for (int j = 0; j < JOINT_COUNT; j++) setup_joint(j, j < 2);
    send_tick(0);
    it = '0; it.action = ACT_START; it.joint = JOINT_W'(1); it.position = 32'h7fffffff;
    send_item(it);
    it = '0; it.action = ACT_GAINS; it.joint = JOINT_W'(1);
    it.stiffness = 31'h7fffffff; it.damping = 31'h7fffffff;
    send_item(it);
    it = '0; it.action = ACT_TICK; it.joint = JOINT_W'(1); it.position = 32'h80000000;
    it.velocity = 32'h7fffffff; it.coriolis = 32'h80000000;
    it.prior_torque = 32'h7fffffff;
    send_item(it);
    send_set(7, 0, 0);    // full valid set
    send_set(3, 0, 0);    // too few elements
    send_set(7, 1, 0);    // out-of-limit element
    send_set(2, 0, 1);    // joint index beyond the arm
    it = '0; it.action = 3'd6; it.joint = JOINT_W'(2); send_item(it);   // unknown action
    it = '0; it.action = ACT_TICK; it.joint = JOINT_W'(7); send_item(it); // absent joint
    drain();

    // -------- register extremes --------
    write_reg(CFG_CORIOLIS_SCALE, 32'h80000000);
    write_reg(CFG_TORQUE_STEP_MAX, 32'h7fffffff);
    write_reg(CFG_GAIN_BLEND, 32'h1ffff);   // above unity, clipped
    for (int j = 0; j < JOINT_COUNT; j++) send_tick(j);
    send_set(9, 0, 0);    // too many elements
    drain();
    write_reg(CFG_CORIOLIS_SCALE, 32'h7fffffff);
    write_reg(CFG_TORQUE_STEP_MAX, 32'd0);
    write_reg(CFG_GAIN_BLEND, 32'd0);
    for (int j = 0; j < JOINT_COUNT; j++) send_tick(j);
    drain();

    // -------- random phases --------
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(CFG_CORIOLIS_SCALE, rnd32());
      write_reg(CFG_TORQUE_STEP_MAX, {1'b0, 31'($urandom)} >> $urandom_range(0, 14));
      write_reg(CFG_GAIN_BLEND, 32'($urandom_range(0, 70000)));
      n = 0;
      while (n < 90) begin
        sel = $urandom_range(0, 19);
        if (sel < 9) begin send_tick($urandom_range(0, 6)); n++; end
        else if (sel < 12) begin send_set(7, 0, 0); n += 7; end
        else if (sel == 12) begin send_set($urandom_range(1, 10), 0, 0); n += 3; end
        else if (sel == 13) begin send_set(7, 1, 1'($urandom_range(0, 1))); n += 7; end
        else if (sel == 14) begin
          it = random_noise(); it.action = ACT_GAINS;
          it.joint = JOINT_W'($urandom_range(0, 6));
          it.stiffness = rnd_gain(); it.damping = rnd_gain();
          send_item(it); n++;
        end else if (sel == 15) begin
          it = random_noise(); it.action = ACT_START;
          it.joint = JOINT_W'($urandom_range(0, 6));
          send_item(it); n++;
        end else if (sel == 16) begin
          setup_joint($urandom_range(0, 6), 1'($urandom)); n++;
        end else begin
          // noise: unknown actions or absent joint, never an element
          it = random_noise();
          if (it.action == ACT_ELEMENT) it.action = 3'd7;
          if (it.action <= ACT_START && it.action != ACT_ELEMENT) it.joint = JOINT_W'(7);
          send_item(it);
        end
      end
      drain();
    end

    if (sb.failures == 0 && sb.expected_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
